FILE: src/dq_pkg.sv
// shared constants, codes and types of the double-ended queue
`timescale 1ns / 1ps
package dq_pkg;

  localparam int DEPTH   = 16;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int REQ_W   = 3;
  localparam int STAT_W  = 2;
  localparam int OP_W    = 3;

  // request codes
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_TRAVERSE   = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // cell operations
  localparam logic [OP_W-1:0] OP_HOLD       = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;
  localparam logic [OP_W-1:0] OP_ROTATE     = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

FILE: src/dq_req_if.sv
// request channel of the double-ended queue
`timescale 1ns / 1ps
interface dq_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [dq_pkg::REQ_W-1:0]             req_type;
  logic signed [dq_pkg::DATA_W-1:0]     item_value;

  modport source (output valid, output req_type, output item_value, input ready);
  modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

FILE: src/dq_rsp_if.sv
// result channel of the double-ended queue
`timescale 1ns / 1ps
interface dq_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dq_pkg::DATA_W-1:0]     result_value;
  logic [dq_pkg::STAT_W-1:0]            status;
  logic                                 last_of_run;

  modport source (output valid, output result_value, output status, output last_of_run,
                  input ready);
  modport sink   (input valid, input result_value, input status, input last_of_run,
                  output ready);
endinterface

FILE: src/dq_cell.sv
// one storage cell of the queue chain, holding one item and its occupied flag
`timescale 1ns / 1ps
module dq_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  dq_pkg::cell_ctrl_t               ctrl,
  input  logic signed [dq_pkg::DATA_W-1:0] left_data,
  input  logic                             left_occ,
  input  logic signed [dq_pkg::DATA_W-1:0] right_data,
  input  logic                             right_occ,
  input  logic signed [dq_pkg::DATA_W-1:0] head_data,
  output logic signed [dq_pkg::DATA_W-1:0] data,
  output logic                             occ
);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      case (ctrl.op)
        dq_pkg::OP_PUSH_FRONT: occ <= left_occ;
        dq_pkg::OP_POP_FRONT:  occ <= right_occ;
        dq_pkg::OP_PUSH_BACK:  occ <= occ | left_occ;
        dq_pkg::OP_POP_BACK:   occ <= occ & right_occ;
        default:               occ <= occ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      dq_pkg::OP_PUSH_FRONT: data <= left_data;
      dq_pkg::OP_POP_FRONT:  data <= right_data;
      dq_pkg::OP_PUSH_BACK: begin
        if (!occ && left_occ) begin
          data <= ctrl.value;
        end
      end
      dq_pkg::OP_ROTATE: begin
        // last occupied cell wraps the front item round
        if (occ) begin
          data <= right_occ ? right_data : head_data;
        end
      end
      default: data <= data;
    endcase
  end

endmodule

FILE: src/dq_chain.sv
// row of queue cells, front item in cell zero, items packed towards the front
`timescale 1ns / 1ps
module dq_chain (
  input  logic                             clk,
  input  logic                             rst,
  input  dq_pkg::cell_ctrl_t               ctrl,
  output logic signed [dq_pkg::DATA_W-1:0] head_data,
  output logic signed [dq_pkg::DATA_W-1:0] back_data,
  output logic                             empty,
  output logic                             full
);

  logic signed [dq_pkg::DATA_W-1:0] data [dq_pkg::DEPTH];
  logic [dq_pkg::DEPTH-1:0]         occ;
  logic signed [dq_pkg::DATA_W-1:0] left_data  [dq_pkg::DEPTH];
  logic signed [dq_pkg::DATA_W-1:0] right_data [dq_pkg::DEPTH];
  logic [dq_pkg::DEPTH-1:0]         left_occ;
  logic [dq_pkg::DEPTH-1:0]         right_occ;

  genvar g;
  generate
    for (g = 0; g < dq_pkg::DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign left_data[g] = ctrl.value;
        assign left_occ[g]  = 1'b1;
      end else begin : g_mid
        assign left_data[g] = data[g-1];
        assign left_occ[g]  = occ[g-1];
      end
      if (g == dq_pkg::DEPTH - 1) begin : g_last
        assign right_data[g] = data[0];
        assign right_occ[g]  = 1'b0;
      end else begin : g_inner
        assign right_data[g] = data[g+1];
        assign right_occ[g]  = occ[g+1];
      end

      dq_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .left_data (left_data[g]),
        .left_occ  (left_occ[g]),
        .right_data(right_data[g]),
        .right_occ (right_occ[g]),
        .head_data (head_data),
        .data      (data[g]),
        .occ       (occ[g])
      );
    end
  endgenerate

  assign head_data = data[0];
  assign empty     = !occ[0];
  assign full      = occ[dq_pkg::DEPTH-1];

  // the back item is the one occupied cell whose right neighbour is free
  always_comb begin
    back_data = '0;
    for (int i = 0; i < dq_pkg::DEPTH; i++) begin
      if (occ[i] && !right_occ[i]) begin
        back_data = back_data | data[i];
      end
    end
  end

endmodule

FILE: src/double_ended_queue_top.sv
// double-ended queue top level: request decode, traverse sequencing, result register
//
// Requests arrive on req (req_type, item_value) and results leave on rsp
// (result_value, status, last_of_run), both valid/ready channels.
// Items live in a row of 16 cells; the front item sits in cell zero.
// Push front, pop front, push back and pop back each give one result,
// registered and shown in the cycle after acceptance; a new request is
// taken every cycle while rsp keeps up and no traverse runs.
// Traverse first loads its item count, then rotates the occupied cells by one
// place per cycle while rsp keeps up, emitting the front item each time, and
// ends with the chain back in its order.
// While a traverse runs no request is accepted.
// Pops and traverses on an empty queue answer with status empty, pushes on
// a full queue with status full; reserved request types give no result.
// Reset empties the queue and drops any pending result.
// When rsp stalls, the result is held in its register and req.ready falls
// until the result is taken.
`timescale 1ns / 1ps
module double_ended_queue_top (
  input logic  clk,
  input logic  rst,
  dq_req_if.sink   req,
  dq_rsp_if.source rsp
);

  dq_pkg::cell_ctrl_t               ctrl;
  logic signed [dq_pkg::DATA_W-1:0] head_data;
  logic signed [dq_pkg::DATA_W-1:0] back_data;
  logic                             empty;
  logic                             full;

  logic                             busy, busy_next;
  logic [dq_pkg::CNT_W-1:0]         count, count_next;
  logic [dq_pkg::CNT_W-1:0]         remain, remain_next;
  logic                             out_valid, out_valid_next;
  logic signed [dq_pkg::DATA_W-1:0] out_value, out_value_next;
  logic [dq_pkg::STAT_W-1:0]        out_status, out_status_next;
  logic                             out_last, out_last_next;
  logic                             out_load;
  logic                             slot_free;
  logic                             accept;

  dq_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .head_data(head_data),
    .back_data(back_data),
    .empty    (empty),
    .full     (full)
  );

  assign slot_free = !out_valid || rsp.ready;
  assign req.ready = !busy && slot_free;
  assign accept    = req.valid && req.ready;

  always_comb begin
    ctrl.op         = dq_pkg::OP_HOLD;
    ctrl.value      = req.item_value;
    busy_next       = busy;
    count_next      = count;
    remain_next     = remain;
    out_load        = 1'b0;
    out_value_next  = '0;
    out_status_next = dq_pkg::STAT_OK;
    out_last_next   = 1'b1;
    if (accept) begin
      case (req.req_type)
        dq_pkg::REQ_PUSH_FRONT, dq_pkg::REQ_PUSH_BACK: begin
          out_load = 1'b1;
          if (full) begin
            out_status_next = dq_pkg::STAT_FULL;
          end else begin
            ctrl.op    = (req.req_type == dq_pkg::REQ_PUSH_FRONT) ?
                         dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK;
            count_next = count + dq_pkg::CNT_W'(1);
          end
        end
        dq_pkg::REQ_POP_FRONT, dq_pkg::REQ_POP_BACK: begin
          out_load = 1'b1;
          if (empty) begin
            out_status_next = dq_pkg::STAT_EMPTY;
          end else if (req.req_type == dq_pkg::REQ_POP_FRONT) begin
            ctrl.op        = dq_pkg::OP_POP_FRONT;
            out_value_next = head_data;
            count_next     = count - dq_pkg::CNT_W'(1);
          end else begin
            ctrl.op        = dq_pkg::OP_POP_BACK;
            out_value_next = back_data;
            count_next     = count - dq_pkg::CNT_W'(1);
          end
        end
        dq_pkg::REQ_TRAVERSE: begin
          if (empty) begin
            out_load        = 1'b1;
            out_status_next = dq_pkg::STAT_EMPTY;
          end else begin
            busy_next   = 1'b1;
            remain_next = count;
          end
        end
        default: begin
        end
      endcase
    end else if (busy && slot_free) begin
      ctrl.op        = dq_pkg::OP_ROTATE;
      out_load       = 1'b1;
      out_value_next = head_data;
      out_last_next  = (remain == dq_pkg::CNT_W'(1));
      remain_next    = remain - dq_pkg::CNT_W'(1);
      busy_next      = (remain != dq_pkg::CNT_W'(1));
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (rsp.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      count     <= '0;
      remain    <= '0;
      out_valid <= 1'b0;
    end else begin
      busy      <= busy_next;
      count     <= count_next;
      remain    <= remain_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value  <= out_value_next;
      out_status <= out_status_next;
      out_last   <= out_last_next;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.result_value = out_value;
  assign rsp.status       = out_status;
  assign rsp.last_of_run  = out_last;

  a_full_matches_count: assert property (@(posedge clk) disable iff (rst)
    full == (count == dq_pkg::CNT_W'(dq_pkg::DEPTH)))
    else $error("full flag of the chain disagrees with the item count");

  a_empty_matches_count: assert property (@(posedge clk) disable iff (rst)
    empty == (count == '0))
    else $error("empty flag of the chain disagrees with the item count");

  a_traverse_has_items: assert property (@(posedge clk) disable iff (rst)
    busy |-> (remain != '0 && remain <= count))
    else $error("traverse running with no items left to emit");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !req.ready)
    else $error("request taken during a traverse");

endmodule
